// ----- sv/mrfc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Meter reply frame checker package
// Shared word types, reply kind codes, status codes and CRC helpers.
// ----------------------------------------------------------------------------
package mrfc_pkg;

   localparam int unsigned StoreDepth = 12;
   localparam logic [4:0] IdlePos = 5'd31;
   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'hA001;

   // Reciprocal of 100 scaled by 2**26, rounded up. Exact for 20-bit inputs.
   localparam int unsigned RecipShift = 26;
   localparam logic [19:0] Recip100 = 20'd671089;

   localparam logic [2:0] KIND_READY   = 3'd0;
   localparam logic [2:0] KIND_VOLTAGE = 3'd1;
   localparam logic [2:0] KIND_CURRENT = 3'd2;
   localparam logic [2:0] KIND_POWER   = 3'd3;
   localparam logic [2:0] KIND_ENERGY  = 3'd4;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_CRC  = 2'd1,
      STATUS_DATA = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic [2:0] reply_kind;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  kind_out;
      logic [31:0] value_first;
      logic [23:0] value_second;
      logic [23:0] value_third;
   } rsp_type;

   // One finished frame, handed from the front end to the decoder.
   typedef struct packed {
      status_type                 status;
      logic [2:0]                 kind;
      logic [StoreDepth-1:0][7:0] payload;
   } frame_type;

   function automatic logic [4:0] frame_len(input logic [2:0] kind);
      logic [4:0] len;
      begin
         unique case (kind)
            KIND_VOLTAGE, KIND_CURRENT: len = 5'd12;
            KIND_POWER:                 len = 5'd15;
            KIND_ENERGY:                len = 5'd19;
            default:                    len = 5'd4;
         endcase
         return len;
      end
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      begin
         c = crc ^ {8'd0, b};
         for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
               c = (c >> 1) ^ CrcPoly;
            end else begin
               c = c >> 1;
            end
         end
         return c;
      end
   endfunction

endpackage
`default_nettype wire

// ----- sv/mrfc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Meter reply frame checker front end
// Tracks byte position and CRC, captures payload bytes, checks each frame.
// ----------------------------------------------------------------------------
module mrfc_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  accept,
   input  mrfc_pkg::req_type    req,
   output logic                 push,
   output mrfc_pkg::frame_type  frame
);

   logic [15:0] crc_ff, crc_in;
   logic [4:0]  pos_ff, pos_in;
   logic [2:0]  kind_ff, kind_in;
   logic [7:0]  low_ff, low_in;
   logic [mrfc_pkg::StoreDepth-1:0][7:0] store_ff, store_in;

   logic [15:0] crc_cur;
   logic [4:0]  pos_cur;
   logic [4:0]  len;
   logic        is_ready_kind;

   always_comb begin
      crc_in   = crc_ff;
      pos_in   = pos_ff;
      kind_in  = kind_ff;
      low_in   = low_ff;
      store_in = store_ff;
      push     = 1'b0;
      crc_cur  = crc_ff;
      pos_cur  = pos_ff;

      if (req.frame_start) begin
         kind_in = req.reply_kind;
         pos_cur = 5'd0;
         crc_cur = mrfc_pkg::CrcInit;
      end
      len = mrfc_pkg::frame_len(kind_in);
      is_ready_kind = (kind_in == mrfc_pkg::KIND_READY) || (kind_in > mrfc_pkg::KIND_ENERGY);

      frame.kind    = kind_in;
      frame.payload = store_ff;
      if ((low_ff != crc_cur[7:0]) || (req.rx_byte != crc_cur[15:8])) begin
         frame.status = mrfc_pkg::STATUS_CRC;
      end else if (is_ready_kind && (store_ff[0] != 8'd0)) begin
         frame.status = mrfc_pkg::STATUS_DATA;
      end else begin
         frame.status = mrfc_pkg::STATUS_OK;
      end

      if (accept) begin
         pos_in = pos_cur;
         crc_in = crc_cur;
         if (pos_cur < len) begin
            for (int i = 0; i < mrfc_pkg::StoreDepth; i++) begin
               if (pos_cur == 5'(i + 1)) begin
                  store_in[i] = req.rx_byte;
               end
            end
            if (pos_cur < len - 5'd2) begin
               crc_in = mrfc_pkg::crc_byte(crc_cur, req.rx_byte);
               pos_in = pos_cur + 5'd1;
            end else if (pos_cur == len - 5'd2) begin
               low_in = req.rx_byte;
               pos_in = pos_cur + 5'd1;
            end else begin
               pos_in = mrfc_pkg::IdlePos;
               push   = 1'b1;
            end
         end
      end else begin
         kind_in = kind_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= mrfc_pkg::CrcInit;
         pos_ff  <= 5'd0;
         kind_ff <= mrfc_pkg::KIND_READY;
         low_ff  <= 8'd0;
      end else begin
         crc_ff  <= crc_in;
         pos_ff  <= pos_in;
         kind_ff <= kind_in;
         low_ff  <= low_in;
      end
      store_ff <= store_in;
   end

endmodule
`default_nettype wire

// ----- sv/mrfc_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Meter reply frame checker queue
// Two-entry queue of checked frames between the front end and the decoder.
// ----------------------------------------------------------------------------
module mrfc_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  mrfc_pkg::frame_type  push_frame,
   output logic                 full,
   output logic                 head_valid,
   input  wire                  pop,
   output mrfc_pkg::frame_type  head_frame
);

   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   mrfc_pkg::frame_type slot_ff [2];

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_frame = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule
`default_nettype wire

// ----- sv/mrfc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Meter reply frame checker decoder
// Divides power fields by 100, assembles phase values, holds the result word.
// ----------------------------------------------------------------------------
module mrfc_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  head_valid,
   input  mrfc_pkg::frame_type  head_frame,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output mrfc_pkg::rsp_type    rsp_data
);

   logic                 s1_valid_ff;
   mrfc_pkg::frame_type  s1_frame_ff;
   logic [2:0][13:0]     s1_quot_ff, s1_quot_in;
   logic                 out_valid_ff;
   mrfc_pkg::rsp_type    out_ff, out_in;
   logic                 out_en, s1_en;

   assign out_en    = !out_valid_ff || rsp_ready;
   assign s1_en     = !s1_valid_ff || out_en;
   assign pop       = head_valid && s1_en;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Power divide: multiply by the scaled reciprocal and keep the high bits.
   always_comb begin
      logic [19:0] raw;
      logic [39:0] prod;
      for (int i = 0; i < 3; i++) begin
         raw  = {head_frame.payload[3*i+3][3:0], head_frame.payload[3*i+5],
                 head_frame.payload[3*i+4]};
         prod = raw * mrfc_pkg::Recip100;
         s1_quot_in[i] = prod[mrfc_pkg::RecipShift +: 14];
      end
   end

   always_comb begin
      logic [11:0][7:0] p;
      p = s1_frame_ff.payload;
      out_in.status       = s1_frame_ff.status;
      out_in.kind_out     = s1_frame_ff.kind;
      out_in.value_first  = 32'd0;
      out_in.value_second = 24'd0;
      out_in.value_third  = 24'd0;
      if (s1_frame_ff.status == mrfc_pkg::STATUS_OK) begin
         case (s1_frame_ff.kind)
            mrfc_pkg::KIND_VOLTAGE, mrfc_pkg::KIND_CURRENT: begin
               out_in.value_first  = {8'd0, p[0], p[2], p[1]};
               out_in.value_second = {p[3], p[5], p[4]};
               out_in.value_third  = {p[6], p[8], p[7]};
            end
            mrfc_pkg::KIND_POWER: begin
               out_in.value_first  = {18'd0, s1_quot_ff[0]};
               out_in.value_second = {10'd0, s1_quot_ff[1]};
               out_in.value_third  = {10'd0, s1_quot_ff[2]};
            end
            mrfc_pkg::KIND_ENERGY: begin
               out_in.value_first = {p[1], p[0], p[3], p[2]};
            end
            default: begin
               out_in.value_first = 32'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= head_valid;
         end
         if (out_en) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
      if (pop) begin
         s1_frame_ff <= head_frame;
         s1_quot_ff  <= s1_quot_in;
      end
      if (out_en && s1_valid_ff) begin
         out_ff <= out_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/meter_reply_frame_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Meter reply frame checker
// Checks Modbus CRC-16 of meter reply frames and decodes the reply values.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one reply byte per word. frame_start marks the
//   first byte of a reply, and reply_kind is sampled with it. Frames are
//   4 bytes (ready), 12 (voltage, current), 15 (power) or 19 (energy); the
//   last two bytes are the CRC, low byte first.
//   The rsp_ channel gives one word per complete frame: status, kind and
//   the decoded values, all values zero when status is not ok.
//   Bytes outside a frame and frames cut short by a new start give no word.
//   Throughput is one byte per cycle while the queue is not full. A finished
//   frame goes from the queue head, where three 20x20 reciprocal multipliers
//   do the power divide, into the decode stage register, then through the
//   stage that assembles the values into the output register.
//   Reset sets the CRC to 0xFFFF, the position to the start of a ready frame
//   and empties the queue and the decoder.
//   When the receiver stalls, the result is held in the output register, one
//   more finished frame waits in the decode stage and up to two in the
//   queue; req_ready falls only once that queue is full.
// ----------------------------------------------------------------------------
module meter_reply_frame_checker (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  mrfc_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output mrfc_pkg::rsp_type  rsp_data
);

   logic                accept;
   logic                push;
   logic                full;
   logic                head_valid;
   logic                pop;
   mrfc_pkg::frame_type push_frame;
   mrfc_pkg::frame_type head_frame;

   // Bytes are taken whenever a finished frame would have room to land.
   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   mrfc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .push   (push),
      .frame  (push_frame)
   );

   mrfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .full       (full),
      .head_valid (head_valid),
      .pop        (pop),
      .head_frame (head_frame)
   );

   mrfc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_frame (head_frame),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

// ----- dv/mrfc_reply_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Meter reply frame checker - reply predictor and comparator
// Follows every accepted byte word with its own copy of the frame state,
// predicts the result word of each finished frame and compares it with what
// the block returns.
// ----------------------------------------------------------------------------
module mrfc_reply_checker
   import mrfc_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   input  wire     req_ready,
   input  req_type req_data,
   input  wire     rsp_valid,
   input  wire     rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      replies_owed
);

   logic [15:0] crc_acc;
   logic [4:0]  frame_pos;
   logic [2:0]  frame_kind;
   logic [7:0]  frame_bytes [1:StoreDepth];
   logic [7:0]  crc_low_seen;
   rsp_type     owed_replies [$];
   int          mismatches = 0;
   int          owed_count = 0;

   assign mismatch_count = mismatches;
   assign replies_owed   = owed_count;

   // Bitwise Modbus CRC-16, reflected polynomial, one byte at a time.
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

   // Unknown kind codes are treated as ready replies.
   function automatic int reply_length(input logic [2:0] kind);
      case (kind)
         KIND_VOLTAGE, KIND_CURRENT: return 12;
         KIND_POWER:                 return 15;
         KIND_ENERGY:                return 19;
         default:                    return 4;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch in %s: got %0h, expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic follow_byte(input req_type w);
      int          len;
      logic [4:0]  pos;
      logic [19:0] raw;
      rsp_type     r;
      if (w.frame_start) begin
         frame_kind = w.reply_kind;
         frame_pos  = '0;
         crc_acc    = CrcInit;
      end
      len = reply_length(frame_kind);
      pos = frame_pos;
      // Past the end of a frame everything is dropped until the next start.
      if (pos >= len) begin
         return;
      end
      if (pos >= 1 && pos <= StoreDepth) begin
         frame_bytes[pos] = w.rx_byte;
      end
      if (pos < len - 2) begin
         crc_acc   = crc_step(crc_acc, w.rx_byte);
         frame_pos = pos + 5'd1;
         return;
      end
      if (pos == len - 2) begin
         crc_low_seen = w.rx_byte;
         frame_pos    = pos + 5'd1;
         return;
      end
      frame_pos  = IdlePos;
      r          = '0;
      r.kind_out = frame_kind;
      if (crc_low_seen != crc_acc[7:0] || w.rx_byte != crc_acc[15:8]) begin
         r.status = STATUS_CRC;
      end else if (frame_kind == KIND_READY || frame_kind > KIND_ENERGY) begin
         r.status = (frame_bytes[1] != 8'h00) ? STATUS_DATA : STATUS_OK;
      end else begin
         r.status = STATUS_OK;
         case (frame_kind)
            KIND_ENERGY: begin
               r.value_first = {frame_bytes[2], frame_bytes[1], frame_bytes[4], frame_bytes[3]};
            end
            KIND_POWER: begin
               raw = {frame_bytes[4][3:0], frame_bytes[6], frame_bytes[5]};
               r.value_first = 32'(raw / 100);
               raw = {frame_bytes[7][3:0], frame_bytes[9], frame_bytes[8]};
               r.value_second = 24'(raw / 100);
               raw = {frame_bytes[10][3:0], frame_bytes[12], frame_bytes[11]};
               r.value_third = 24'(raw / 100);
            end
            default: begin
               r.value_first  = {8'h00, frame_bytes[1], frame_bytes[3], frame_bytes[2]};
               r.value_second = {frame_bytes[4], frame_bytes[6], frame_bytes[5]};
               r.value_third  = {frame_bytes[7], frame_bytes[9], frame_bytes[8]};
            end
         endcase
      end
      owed_replies.push_back(r);
   endtask

   task automatic check_reply(input rsp_type got);
      rsp_type want;
      if (owed_replies.size() == 0) begin
         report_mismatch("word with no reply owed", got.value_first, 32'h0);
         return;
      end
      want = owed_replies.pop_front();
      if (got.status !== want.status)
         report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.kind_out !== want.kind_out)
         report_mismatch("kind_out", 32'(got.kind_out), 32'(want.kind_out));
      if (got.value_first !== want.value_first)
         report_mismatch("value_first", got.value_first, want.value_first);
      if (got.value_second !== want.value_second)
         report_mismatch("value_second", 32'(got.value_second), 32'(want.value_second));
      if (got.value_third !== want.value_third)
         report_mismatch("value_third", 32'(got.value_third), 32'(want.value_third));
   endtask

   // Results are checked before the byte of the same edge is followed; a
   // reply can never leave on the edge that accepts its last byte.
   always @(posedge clock) begin
      if (reset) begin
         crc_acc      = CrcInit;
         frame_pos    = '0;
         frame_kind   = KIND_READY;
         crc_low_seen = '0;
         for (int i = 1; i <= StoreDepth; i++) begin
            frame_bytes[i] = '0;
         end
         owed_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_reply(rsp_data);
         end
         if (req_valid && req_ready) begin
            follow_byte(req_data);
         end
      end
      owed_count <= owed_replies.size();
   end

endmodule

// ----- dv/meter_reply_frame_checker_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Meter reply frame checker testbench
// Sends meter reply frames of every kind, good and broken, one byte word at a
// time, with random idling on both channels; a checker module beside the block
// predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module meter_reply_frame_checker_tb;
   import mrfc_pkg::*;

   localparam int PhaseWords  = 550;
   localparam int CycleLimit  = 200000;
   localparam int DrainCycles = 8;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct = 22;
   int recv_idle_pct = 69;
   int words_sent    = 0;
   int cycle_count   = 0;
   int mismatches;
   int owed;

   meter_reply_frame_checker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   mrfc_reply_checker reply_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatches),
      .replies_owed   (owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random; the rate is changed per phase by the
   // stimulus process below.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Hands one byte word to the block. The sender may idle first; once valid
   // is raised it stays up with the same payload until the word is taken.
   // The ready sampled just after the edge is the value the block saw there.
   task automatic send_word(input logic [7:0] b, input logic [2:0] kind, input logic start);
      req_type w;
      w.rx_byte     = b;
      w.reply_kind  = kind;
      w.frame_start = start;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   // Payload bytes lean toward the extremes so that saturated fields show up.
   // A fill of one gives all ones, a fill of two all zeros.
   function automatic logic [7:0] payload_byte(input int fill);
      if (fill == 1)
         return 8'hFF;
      if (fill == 2)
         return 8'h00;
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Builds and sends one reply frame. The check bytes are computed over the
   // frame, then one bit of them is flipped when bad_crc is set. Only the
   // first keep bytes go out, so a small keep cuts the frame short. For ready
   // replies (and the unused kind codes, which behave like them) ready_zero
   // forces the data byte to zero so that the frame passes the data check.
   task automatic send_reply(input logic [2:0] kind, input logic with_start,
                             input logic bad_crc, input int keep, input int fill,
                             input logic ready_zero);
      logic [7:0]  frame [$];
      logic [7:0]  b;
      logic [15:0] crc;
      int          len;
      len = reply_check.reply_length(kind);
      crc = CrcInit;
      for (int i = 0; i < len - 2; i++) begin
         b = payload_byte(fill);
         if (i == 1 && len == 4 && ready_zero)
            b = 8'h00;
         frame.push_back(b);
         crc = reply_check.crc_step(crc, b);
      end
      if (bad_crc)
         crc ^= 16'h0001 << $urandom_range(15);
      frame.push_back(crc[7:0]);
      frame.push_back(crc[15:8]);
      for (int i = 0; i < len && i < keep; i++) begin
         // Only the first word carries the kind; elsewhere the field is noise.
         send_word(frame[i], (i == 0) ? kind : 3'($urandom_range(7)), (i == 0) && with_start);
         words_sent++;
      end
   endtask

   // Random frames: mostly well formed with random content, the rest carry
   // a bad CRC, are cut short by the next start, or are stray bytes that the
   // block must drop (or, after a cut frame, fold into it).
   task automatic random_frames(input int count);
      int          stop_at;
      int          pick;
      int          fill;
      logic [2:0]  kind;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         pick = $urandom_range(99);
         kind = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
         fill = ($urandom_range(19) == 0) ? 1 : (($urandom_range(19) == 0) ? 2 : 0);
         if (pick < 75) begin
            send_reply(kind, 1'b1, 1'b0, 32, fill, $urandom_range(3) != 0);
         end else if (pick < 85) begin
            send_reply(kind, 1'b1, 1'b1, 32, fill, 1'b1);
         end else if (pick < 93) begin
            send_reply(kind, 1'b1, 1'($urandom_range(1)), $urandom_range(18, 1), fill,
                       1'($urandom_range(1)));
         end else begin
            repeat ($urandom_range(3, 1)) begin
               send_word(8'($urandom_range(255)), 3'($urandom_range(7)), 1'b0);
               words_sent++;
            end
         end
      end
   endtask

   // Drops valid and holds the sender back until every owed result word has
   // come back. The first edge lets the owed count take in the last byte.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (owed != 0);
   endtask

   // Watchdog: a hung handshake ends the run here.
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Phase one: the sender idles a little, the receiver a lot.
      send_idle_pct = 22;
      recv_idle_pct = 69;

      // Right after reset the block sits at the start of a ready frame, so
      // four bytes without a start mark must form a ready reply.
      send_reply(KIND_READY, 1'b0, 1'b0, 4, 0, 1'b1);
      // A ready reply with a nonzero data byte and a good CRC is a data error.
      send_reply(KIND_READY, 1'b1, 1'b0, 4, 1, 1'b0);
      // A voltage reply cut after three bytes by a new start gives nothing;
      // the new frame uses kind seven, which is handled as a ready reply.
      send_reply(KIND_VOLTAGE, 1'b1, 1'b0, 3, 0, 1'b0);
      send_reply(3'd7, 1'b1, 1'b0, 4, 2, 1'b1);
      // A stray byte after a finished frame is dropped.
      send_word(8'hA5, KIND_ENERGY, 1'b0);
      // An unused kind code with a broken CRC reports the CRC error and the
      // sampled kind.
      send_reply(3'd5, 1'b1, 1'b1, 4, 0, 1'b1);

      random_frames(PhaseWords);
      hold_until_drained();

      // Phase two: the sender idles a lot, the receiver a little.
      send_idle_pct = 69;
      recv_idle_pct = 22;
      random_frames(PhaseWords);
      hold_until_drained();

      // Phase three: back to back on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_frames(PhaseWords);
      hold_until_drained();

      // Waiting out DrainCycles catches any result word the block should not give.
      repeat (DrainCycles) @(posedge clock);

      if (mismatches == 0 && owed == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
